/* rtl/itrd_pkg.sv */
// Package for the integer to radix digit converter: sizes, codes, command and
// status structs and the character tables.
// No dependencies; every other file imports it.
`default_nettype none

package itrd_pkg;

   localparam int VALUE_BITS = 32;
   localparam int STEP_BITS  = 4;
   localparam int DIV_CYCLES = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_BITS   = DIV_CYCLES * STEP_BITS;

   localparam int RADIX_W    = 6;
   localparam int DIGIT_W    = 6;
   localparam int CHAR_W     = 7;
   localparam int IN_W       = 32;
   localparam int ERR_LEN    = 10;

   localparam int STEP_CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int CNT_W      = $clog2(VALUE_BITS + 1);
   localparam int ERR_IDX_W  = $clog2(ERR_LEN);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] ADDR_RADIX  = CSR_ADDR_W'(0);
   localparam logic [RADIX_W-1:0]    RADIX_RESET = RADIX_W'(10);
   localparam logic [RADIX_W-1:0]    RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0]    RADIX_MAX   = RADIX_W'(36);

   localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(8'h30);
   localparam logic [CHAR_W-1:0] CHAR_A    = CHAR_W'(8'h61);

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic radix_ok;
      logic div_done;
      logic out_last;
   } status_type;

   // digit value 0..35 to '0'..'9', 'a'..'z'
   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] ext;
      ext = CHAR_W'(d);
      if (d < DIGIT_W'(10)) begin
         return CHAR_ZERO + ext;
      end else begin
         return CHAR_A + ext - CHAR_W'(10);
      end
   endfunction

   // text BASE_ERROR, one character per index
   function automatic logic [CHAR_W-1:0] err_char(input logic [ERR_IDX_W-1:0] idx);
      logic [CHAR_W-1:0] c;
      unique case (idx)
         ERR_IDX_W'(0): c = CHAR_W'(8'h42);
         ERR_IDX_W'(1): c = CHAR_W'(8'h41);
         ERR_IDX_W'(2): c = CHAR_W'(8'h53);
         ERR_IDX_W'(3): c = CHAR_W'(8'h45);
         ERR_IDX_W'(4): c = CHAR_W'(8'h5f);
         ERR_IDX_W'(5): c = CHAR_W'(8'h45);
         ERR_IDX_W'(6): c = CHAR_W'(8'h52);
         ERR_IDX_W'(7): c = CHAR_W'(8'h52);
         ERR_IDX_W'(8): c = CHAR_W'(8'h4f);
         ERR_IDX_W'(9): c = CHAR_W'(8'h52);
         default:       c = CHAR_W'(8'h52);
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/itrd_if.sv */
// Channel interfaces of the radix digit converter: request and response.
// Depends on itrd_pkg for the payload widths.
`default_nettype none

interface itrd_req_if
   import itrd_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface itrd_rsp_if
   import itrd_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] digit_char;
   logic              last;
   logic              bad_radix;

   modport source (output valid, output digit_char, output last, output bad_radix,
                   input ready);
   modport sink   (input valid, input digit_char, input last, input bad_radix,
                   output ready);
endinterface

`default_nettype wire

/* rtl/itrd_datapath.sv */
// Datapath: magnitude, shared digit divider, digit stack and output register.
// Depends on itrd_pkg; driven by itrd_ctrl through cmd_type.
`default_nettype none

module itrd_datapath
   import itrd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cmd_type                cmd,
   output      status_type             status,
   input  wire logic [RADIX_W-1:0]     radix,
   input  wire logic signed [IN_W-1:0] value,
   output      logic [CHAR_W-1:0]      digit_char,
   output      logic                   last,
   output      logic                   bad_radix
);

   logic [PAD_BITS-1:0]   quo_ff, quo_in;
   logic [DIGIT_W-1:0]    rem_ff, rem_in;
   logic [STEP_CNT_W-1:0] step_cnt_ff, step_cnt_in;
   logic [DIGIT_W-1:0]    stk_ff [VALUE_BITS];
   logic [DIGIT_W-1:0]    stk_in [VALUE_BITS];
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [ERR_IDX_W-1:0]  err_idx_ff, err_idx_in;
   logic                  err_mode_ff, err_mode_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic                  last_ff, last_in;

   logic [VALUE_BITS-1:0] raw;
   logic [VALUE_BITS-1:0] mag;
   logic [PAD_BITS-1:0]   q_step;
   logic [DIGIT_W-1:0]    r_step;
   logic [DIGIT_W:0]      trial;
   logic                  last_step;
   logic                  radix_ok;

   assign raw      = value[VALUE_BITS-1:0];
   assign mag      = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
   assign radix_ok = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
   assign last_step = (step_cnt_ff == STEP_CNT_W'(DIV_CYCLES - 1));

   // STEP_BITS restoring division steps per cycle
   always_comb begin
      q_step = quo_ff;
      r_step = rem_ff;
      trial  = '0;
      for (int i = 0; i < STEP_BITS; i++) begin
         trial  = {r_step, q_step[PAD_BITS-1]};
         q_step = {q_step[PAD_BITS-2:0], 1'b0};
         if (trial >= {1'b0, radix}) begin
            trial     = trial - {1'b0, radix};
            q_step[0] = 1'b1;
         end
         r_step = trial[DIGIT_W-1:0];
      end
   end

   always_comb begin
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      step_cnt_in = step_cnt_ff;
      stk_in      = stk_ff;
      cnt_in      = cnt_ff;
      err_idx_in  = err_idx_ff;
      err_mode_in = err_mode_ff;
      char_in     = char_ff;
      last_in     = last_ff;

      if (cmd.load) begin
         quo_in      = PAD_BITS'(mag);
         rem_in      = '0;
         step_cnt_in = '0;
         cnt_in      = '0;
         err_idx_in  = '0;
         err_mode_in = !radix_ok;
      end

      if (cmd.step) begin
         quo_in = q_step;
         if (last_step) begin
            // digit done: push remainder, restart on the quotient
            rem_in      = '0;
            step_cnt_in = '0;
            stk_in[0]   = r_step;
            for (int i = 1; i < VALUE_BITS; i++) begin
               stk_in[i] = stk_ff[i-1];
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end else begin
            rem_in      = r_step;
            step_cnt_in = step_cnt_ff + STEP_CNT_W'(1);
         end
      end

      if (cmd.emit) begin
         if (err_mode_ff) begin
            char_in    = err_char(err_idx_ff);
            last_in    = (err_idx_ff == ERR_IDX_W'(ERR_LEN - 1));
            err_idx_in = err_idx_ff + ERR_IDX_W'(1);
         end else begin
            // pop the most significant digit
            char_in = digit_to_char(stk_ff[0]);
            last_in = (cnt_ff == CNT_W'(1));
            for (int i = 0; i < VALUE_BITS - 1; i++) begin
               stk_in[i] = stk_ff[i+1];
            end
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_cnt_ff <= '0;
         cnt_ff      <= '0;
         err_idx_ff  <= '0;
         err_mode_ff <= 1'b0;
      end else begin
         step_cnt_ff <= step_cnt_in;
         cnt_ff      <= cnt_in;
         err_idx_ff  <= err_idx_in;
         err_mode_ff <= err_mode_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      stk_ff  <= stk_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   // step count only reaches its last value while dividing
   assign status.radix_ok = radix_ok;
   assign status.div_done = last_step && (q_step == '0);
   assign status.out_last = last_ff;

   assign digit_char = char_ff;
   assign last       = last_ff;
   assign bad_radix  = err_mode_ff;

endmodule

`default_nettype wire

/* rtl/itrd_ctrl.sv */
// Controller: sequences load, digit division and character output.
// Depends on itrd_pkg; commands itrd_datapath through cmd_type and status_type.
`default_nettype none

module itrd_ctrl
   import itrd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      cmd_type    cmd,
   input  wire status_type status
);

   typedef enum logic [1:0] {
      IDLE,
      DIVIDE,
      FETCH,
      SEND
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      req_fire;
   logic      rsp_fire;

   assign req_fire = req_valid && req_ready_ff;
   assign rsp_fire = rsp_valid_ff && rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = status.radix_ok ? DIVIDE : FETCH;
            end
         end
         DIVIDE: begin
            cmd.step = 1'b1;
            if (status.div_done) begin
               state_in = FETCH;
            end
         end
         FETCH: begin
            cmd.emit = 1'b1;
            state_in = SEND;
         end
         SEND: begin
            if (rsp_fire) begin
               if (status.out_last) begin
                  state_in = IDLE;
               end else begin
                  // next character loads on the same edge as this transfer
                  cmd.emit = 1'b1;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == IDLE);
         rsp_valid_ff <= (state_in == SEND);
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/integer_to_radix_digits_top.sv */
// Integer to radix digits converter, top level: radix register, controller
// and datapath. Depends on itrd_pkg, itrd_if, itrd_ctrl and itrd_datapath.
//
// Usage: write the radix (2..36, reset 10) at byte address 0 of the APB-style
// port while the block is idle. Each transfer on req_chan carries a 32-bit
// signed value; its sign is dropped and the magnitude goes out on rsp_chan as
// lower-case ASCII digits, most significant first, one transfer per digit,
// the final one marked by last. Zero gives the single digit '0'. With a radix
// outside 2..36 the ten characters BASE_ERROR go out with bad_radix set.
// Throughput: one item at a time. Each digit is divided by the shared
// divider, which retires 4 quotient bits per cycle; once the digits are
// stacked, characters go out at one character per cycle while rsp_chan.ready
// is high. The error text skips the divider. req_chan.ready returns in the
// cycle after the last character is taken.
// Stall: a stalled receiver holds the current character and the block waits.
// Reset (synchronous) sets the radix to 10 and returns to idle, ready high.
`default_nettype none

module integer_to_radix_digits_top
   import itrd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   itrd_req_if.sink                   req_chan,
   itrd_rsp_if.source                 rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      logic                  pready
);

   logic [RADIX_W-1:0] radix_ff, radix_in;
   cmd_type            cmd;
   status_type         status;

   assign pready = 1'b1;

   always_comb begin
      radix_in = radix_ff;
      if (psel && penable && pwrite && (paddr == ADDR_RADIX)) begin
         radix_in = pwdata[RADIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   assign prdata = (paddr == ADDR_RADIX) ? CSR_DATA_W'(radix_ff) : '0;

   itrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   itrd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .radix      (radix_ff),
      .value      (req_chan.value),
      .digit_char (rsp_chan.digit_char),
      .last       (rsp_chan.last),
      .bad_radix  (rsp_chan.bad_radix)
   );

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking bench for integer_to_radix_digits_top: predicts each digit
// string on the fly and checks every response transfer against it.
// Depends on itrd_pkg, itrd_if and the top-level RTL.

module tb_top;
   import itrd_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic              err;
   } digit_exp_type;

   localparam int IDLE_LIMIT = 4000;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   itrd_req_if req_chan ();
   itrd_rsp_if rsp_chan ();

   logic [IN_W-1:0]    pending_values[$];
   digit_exp_type      expected_chars[$];
   logic [RADIX_W-1:0] radix_shadow;
   int                 send_idle_pct;
   int                 stall_pct;
   int                 mismatch_count;
   int                 values_sent;
   int                 chars_checked;
   int                 error_texts;
   int                 idle_cycles;

   integer_to_radix_digits_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // expected characters for one value at the given radix
   function automatic void predict_digits(input logic [IN_W-1:0] v,
                                          input logic [RADIX_W-1:0] r);
      string         digit_set;
      string         err_text;
      logic [31:0]   mag;
      logic [31:0]   rdx;
      int            rev[0:32];
      int            n;
      digit_exp_type d;
      digit_set = "0123456789abcdefghijklmnopqrstuvwxyz";
      err_text  = "BASE_ERROR";
      n = 0;
      rdx = 32'(r);
      if (r < RADIX_MIN || r > RADIX_MAX) begin
         for (int k = 0; k < ERR_LEN; k++) begin
            d.ch   = CHAR_W'(err_text[k]);
            d.last = (k == ERR_LEN - 1);
            d.err  = 1'b1;
            expected_chars.push_back(d);
         end
         return;
      end
      // negating the most negative value wraps back to its exact magnitude
      mag = v[IN_W-1] ? -v : v;
      if (mag == 32'd0) begin
         d.ch   = CHAR_W'(digit_set[0]);
         d.last = 1'b1;
         d.err  = 1'b0;
         expected_chars.push_back(d);
         return;
      end
      while (mag != 32'd0) begin
         rev[n] = int'(mag % rdx);
         mag    = mag / rdx;
         n++;
      end
      for (int k = 0; k < n; k++) begin
         d.ch   = CHAR_W'(digit_set[rev[n-1-k]]);
         d.last = (k == n - 1);
         d.err  = 1'b0;
         expected_chars.push_back(d);
      end
   endfunction

   function automatic logic [IN_W-1:0] pick_value(input logic [RADIX_W-1:0] r);
      logic [63:0] p;
      int          n;
      p = 64'd1;
      case ($urandom_range(7))
         0, 1: return $urandom;
         2: return IN_W'($urandom_range(0, 99));
         3: return -IN_W'($urandom_range(1, 99));
         4: begin
            // near a power of the radix, where the digit count steps
            n = $urandom_range(1, 31);
            for (int k = 0; k < n; k++) begin
               if (r >= RADIX_MIN && p * r <= 64'h8000_0000) p = p * r;
            end
            p = p - 64'($urandom_range(0, 1));
            return ($urandom_range(1) != 0) ? -IN_W'(p) : IN_W'(p);
         end
         5: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   // wait until no transfer is outstanding, then let the block settle
   task automatic wait_until_drained();
      while (pending_values.size() != 0 || req_chan.valid || expected_chars.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_radix(input logic [RADIX_W-1:0] r);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_RADIX;
      pwdata  <= CSR_DATA_W'(r);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      radix_shadow = r;
   endtask

   task automatic convert_batch(input bit do_write, input logic [RADIX_W-1:0] r,
                                input logic [IN_W-1:0] vals[$]);
      if (do_write) write_radix(r);
      @(negedge clock);
      foreach (vals[i]) pending_values.push_back(vals[i]);
      wait_until_drained();
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.value <= '0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_chan.valid <= 1'b1;
            req_chan.value <= pending_values.pop_front();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
   end

   // request monitor: every accepted value is predicted at the current radix
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         predict_digits(req_chan.value, radix_shadow);
         values_sent++;
      end
   end

   // response monitor
   always @(posedge clock) begin
      digit_exp_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h", rsp_chan.digit_char));
         end else begin
            e = expected_chars.pop_front();
            if (rsp_chan.digit_char !== e.ch)
               report_mismatch($sformatf("digit_char 0x%02h, want 0x%02h",
                                         rsp_chan.digit_char, e.ch));
            if (rsp_chan.last !== e.last)
               report_mismatch($sformatf("last %b, want %b", rsp_chan.last, e.last));
            if (rsp_chan.bad_radix !== e.err)
               report_mismatch($sformatf("bad_radix %b, want %b",
                                         rsp_chan.bad_radix, e.err));
            if (e.err && e.last) error_texts++;
         end
         chars_checked++;
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles without a transfer", idle_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [IN_W-1:0]    vals[$];
      logic [RADIX_W-1:0] r;
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      radix_shadow   = RADIX_RESET;
      send_idle_pct  = 0;
      stall_pct      = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset radix, base 2 and base 36 extremes, then invalid radices
      convert_batch(1'b0, RADIX_RESET, '{32'd0, 32'd1, 32'hffff_ffff, 32'h7fff_ffff,
                                         32'h8000_0000, 32'd9, 32'd10, -32'd1000000000});
      convert_batch(1'b1, 6'd2, '{32'h8000_0000, 32'h7fff_ffff, 32'd5, 32'd0});
      convert_batch(1'b1, 6'd36, '{32'd35, 32'd36, -32'd1296, 32'h8000_0000,
                                   32'h7fff_ffff});
      convert_batch(1'b1, 6'd0, '{32'd12345});
      convert_batch(1'b1, 6'd1, '{32'd0});
      convert_batch(1'b1, 6'd37, '{-32'd7});
      convert_batch(1'b1, 6'd63, '{32'h8000_0000});

      // random: two radix blocks per idling mode
      for (int blk = 0; blk < 8; blk++) begin
         case (blk / 2)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 82; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 82; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
         endcase
         case (blk)
            0: r = 6'd2;
            1: r = 6'd36;
            3: r = RADIX_W'($urandom_range(37, 63));
            default: r = RADIX_W'($urandom_range(2, 36));
         endcase
         vals.delete();
         for (int i = 0; i < 31; i++) vals.push_back(pick_value(r));
         convert_batch(1'b1, r, vals);
      end

      repeat (20) @(posedge clock);
      $display("converted %0d values into %0d characters (%0d error texts)",
               values_sent, chars_checked, error_texts);
      $display("radix settings 0..63 incl. 2, 10, 36; %0d mismatches", mismatch_count);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("CHECK OK");
      end else begin
         if (expected_chars.size() != 0)
            $display("ERROR: %0d characters never arrived", expected_chars.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
